FILE: rtl/smoothed_cubic_trajectory_interpolator_core_defines.svh
// Assertion macros shared by the interpolator RTL
`ifndef SMOOTHED_CUBIC_TRAJECTORY_INTERPOLATOR_CORE_DEFINES_SVH
`define SMOOTHED_CUBIC_TRAJECTORY_INTERPOLATOR_CORE_DEFINES_SVH

// check a property on every clock edge outside reset
`define SCTI_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check that an antecedent is followed by a consequent in the next cycle
`define SCTI_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/scti_pkg.sv
package scti_pkg;

  localparam int unsigned HIST_DEPTH  = 4;
  localparam int unsigned POS_W       = 32;
  localparam int unsigned COEF_W      = 54;
  localparam int unsigned ACC_W       = 64;
  localparam int unsigned TICK_W      = 8;
  localparam int unsigned Q_SHIFT     = 16;
  localparam int unsigned NUM_COEF    = 4;
  localparam logic [TICK_W-1:0] TICKS_RESET = 8'd70;
  localparam logic [TICK_W-1:0] WEIGHT_SUM  = 8'd6;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_STOP = 1'b1;

  typedef struct packed {
    logic                                   filled;
    logic [TICK_W-1:0]                      tick;
    logic [HIST_DEPTH-1:0][POS_W-1:0]       hist;
    logic [NUM_COEF-1:0][COEF_W-1:0]        coef;
  } row_t;

  typedef struct packed {
    logic re;
    logic we;
  } mem_req_t;

  typedef struct packed {
    logic                     start;
    logic signed [ACC_W-1:0]  dividend;
    logic [TICK_W-1:0]        divisor;
  } div_req_t;

  typedef struct packed {
    logic                     busy;
    logic                     done;
    logic signed [ACC_W-1:0]  quot;
  } div_rsp_t;

endpackage

FILE: rtl/scti_row_mem.sv
module scti_row_mem #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  scti_pkg::mem_req_t req_i,
  input  logic [AW-1:0]     addr_i,
  input  scti_pkg::row_t    wdata_i,
  output scti_pkg::row_t    rdata_o
);
  import scti_pkg::*;

  row_t             mem_q [DEPTH];
  row_t             rd_q;
  logic [DEPTH-1:0] vld_q;
  logic             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (req_i.re) begin
      rd_q <= mem_q[addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.re) begin
        rd_vld_q <= vld_q[addr_i];
      end
      if (req_i.we) begin
        vld_q[addr_i] <= 1'b1;
      end
    end
  end

  assign rdata_o = rd_vld_q ? rd_q : '0;

endmodule

FILE: rtl/scti_div.sv
module scti_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  scti_pkg::div_req_t req_i,
  output scti_pkg::div_rsp_t rsp_o
);
  import scti_pkg::*;

  localparam int unsigned RADIX_BITS = 4;
  localparam int unsigned STEPS      = ACC_W / RADIX_BITS;
  localparam int unsigned CNT_W      = $clog2(STEPS);

  logic                    busy_q;
  logic                    done_q;
  logic                    neg_q;
  logic [CNT_W-1:0]        cnt_q;
  logic [ACC_W-1:0]        num_q;
  logic [ACC_W-1:0]        quo_q;
  logic [TICK_W-1:0]       rem_q;
  logic [TICK_W-1:0]       den_q;
  logic signed [ACC_W-1:0] res_q;

  logic [TICK_W-1:0]       rem_d;
  logic [RADIX_BITS-1:0]   qd;
  logic [ACC_W-1:0]        quo_d;
  logic [TICK_W:0]         trial;

  always_comb begin
    rem_d = rem_q;
    qd    = '0;
    trial = '0;
    for (int i = 0; i < RADIX_BITS; i++) begin
      trial = {rem_d, num_q[ACC_W-1-i]};
      if (trial >= {1'b0, den_q}) begin
        trial = trial - {1'b0, den_q};
        qd[RADIX_BITS-1-i] = 1'b1;
      end
      rem_d = trial[TICK_W-1:0];
    end
    quo_d = {quo_q[ACC_W-RADIX_BITS-1:0], qd};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      neg_q <= req_i.dividend[ACC_W-1];
      num_q <= req_i.dividend[ACC_W-1] ? ACC_W'(-req_i.dividend) : req_i.dividend;
      quo_q <= '0;
      rem_q <= '0;
      den_q <= req_i.divisor;
    end else if (busy_q) begin
      num_q <= {num_q[ACC_W-RADIX_BITS-1:0], {RADIX_BITS{1'b0}}};
      quo_q <= quo_d;
      rem_q <= rem_d;
      if (cnt_q == CNT_W'(STEPS - 1)) begin
        res_q <= neg_q ? -$signed(quo_d) : $signed(quo_d);
      end
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = res_q;

endmodule

FILE: rtl/smoothed_cubic_trajectory_interpolator_core.sv
// Channel   Dir  Payload (low bit up)
// s_axis    in   tdata: axis[2:0], target_pos[34:3]; tuser: op
// m_axis    out  tdata: out_axis[2:0], command_position[34:3]; tuser: segment_start
// apb       in   interp_ticks at address 0
// One item at a time. A tick inside a segment runs three Horner
// steps, each a multiply and a radix-16 divide in the shared divider.
// A tick that starts a segment adds two divides by six.
// Per-axis state sits in one row memory whose rows read as zero until written;
// reset is asynchronous and needs no clearing pass.
// A stalled result holds in the output register and blocks only the next write-back.
`include "smoothed_cubic_trajectory_interpolator_core_defines.svh"

module smoothed_cubic_trajectory_interpolator_core #(
  parameter int unsigned NUM_AXES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // axis, target_pos
  input  logic        s_axis_tuser,   // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // out_axis, command_position
  output logic        m_axis_tuser,   // segment_start
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import scti_pkg::*;

  localparam int unsigned AW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_READ   = 10'b0000000010,
    S_PDIV   = 10'b0000000100,
    S_PWAIT  = 10'b0000001000,
    S_COEF_D = 10'b0000010000,
    S_COEF_C = 10'b0000100000,
    S_MUL    = 10'b0001000000,
    S_HDIV   = 10'b0010000000,
    S_HWAIT  = 10'b0100000000,
    S_OUT    = 10'b1000000000
  } state_e;

  state_e                  state_q, state_d;
  logic [TICK_W-1:0]       ticks_q;
  logic                    op_q;
  logic [2:0]              axis_q;
  logic [POS_W-1:0]        tgt_q;
  row_t                    row_q;
  logic [TICK_W-1:0]       k_q;
  logic                    start_q;
  logic                    pi_q;
  logic [1:0]              hs_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [ACC_W-1:0] prod_q;
  logic signed [ACC_W-1:0] d_q;
  logic                    m_valid_q;
  logic [39:0]             m_data_q;
  logic                    m_user_q;

  mem_req_t                mem_req;
  row_t                    mem_rdata;
  row_t                    mem_wdata;
  row_t                    rd_row;
  logic [AW-1:0]           mem_addr;
  div_req_t                div_req;
  div_rsp_t                div_rsp;

  logic                    s_acc;
  logic                    in_range;
  logic [AW+2:0]           in_addr_ext;
  logic [AW+2:0]           q_addr_ext;
  logic [TICK_W-1:0]       n_eff;
  logic [TICK_W-1:0]       rd_k;
  logic [TICK_W:0]         k_inc;
  logic [TICK_W-1:0]       k_next;
  logic                    out_free;
  logic                    cfg_we;

  logic signed [POS_W+2:0] s_sum;
  logic signed [COEF_W-1:0] v1;
  logic signed [COEF_W-1:0] v2;
  logic signed [COEF_W-1:0] p1;
  logic signed [ACC_W-1:0] c2_full;
  logic signed [ACC_W-1:0] c3_full;
  logic signed [ACC_W-1:0] c_add;
  logic signed [ACC_W-1:0] acc_rnd;
  logic signed [ACC_W-Q_SHIFT-1:0] acc_sh;
  logic [POS_W-1:0]        pos;
  logic [HIST_DEPTH-1:0][POS_W-1:0] hist_new;

  assign n_eff    = (ticks_q == '0) ? TICK_W'(1) : ticks_q;
  assign s_acc    = s_axis_tvalid && s_axis_tready;
  assign in_range = {4'b0, s_axis_tdata[2:0]} < 7'(NUM_AXES);
  assign in_addr_ext = (AW + 3)'(s_axis_tdata[2:0]);
  assign q_addr_ext  = (AW + 3)'(axis_q);
  assign mem_addr = (state_q == S_IDLE) ? in_addr_ext[AW-1:0] : q_addr_ext[AW-1:0];
  assign out_free = !m_valid_q || m_axis_tready;

  assign rd_k   = (mem_rdata.tick >= n_eff) ? '0 : mem_rdata.tick;
  assign k_inc  = {1'b0, k_q} + 1'b1;
  assign k_next = (k_inc >= {1'b0, n_eff}) ? '0 : k_inc[TICK_W-1:0];

  // history after the push of the new target
  always_comb begin
    hist_new = '0;
    hist_new[HIST_DEPTH-1] = tgt_q;
    for (int j = 0; j < HIST_DEPTH - 1; j++) begin
      hist_new[j] = mem_rdata.filled ? mem_rdata.hist[j+1] : tgt_q;
    end
  end

  always_comb begin
    rd_row = mem_rdata;
    if (rd_k == '0) begin
      rd_row.hist   = hist_new;
      rd_row.filled = 1'b1;
    end
  end

  // 1-4-1 weighted window, tangents as half differences
  assign s_sum = pi_q
    ? $signed((POS_W+3)'($signed(row_q.hist[1]))) + ((POS_W+3)'($signed(row_q.hist[2])) <<< 2)
      + (POS_W+3)'($signed(row_q.hist[3]))
    : $signed((POS_W+3)'($signed(row_q.hist[0]))) + ((POS_W+3)'($signed(row_q.hist[1])) <<< 2)
      + (POS_W+3)'($signed(row_q.hist[2]));
  assign v1 = (COEF_W'($signed(row_q.hist[2])) - COEF_W'($signed(row_q.hist[0]))) <<< 15;
  assign v2 = (COEF_W'($signed(row_q.hist[3])) - COEF_W'($signed(row_q.hist[1]))) <<< 15;
  assign p1 = $signed(row_q.coef[0]);

  assign c2_full = (d_q <<< 1) + d_q - (ACC_W'(v1) <<< 1) - ACC_W'(v2);
  assign c3_full = -(d_q <<< 1) + ACC_W'(v1) + ACC_W'(v2);

  always_comb begin
    unique case (hs_q)
      2'd0:    c_add = ACC_W'($signed(row_q.coef[2]));
      2'd1:    c_add = ACC_W'($signed(row_q.coef[1]));
      default: c_add = ACC_W'($signed(row_q.coef[0]));
    endcase
  end

  assign acc_rnd = acc_q[ACC_W-1] ? acc_q + ACC_W'(65535) : acc_q;
  assign acc_sh  = acc_rnd[ACC_W-1:Q_SHIFT];

  always_comb begin
    if (acc_sh > (ACC_W-Q_SHIFT)'(32'sh7fffffff)) begin
      pos = 32'h7fffffff;
    end else if (acc_sh < -(ACC_W-Q_SHIFT)'(64'sh80000000)) begin
      pos = 32'h80000000;
    end else begin
      pos = acc_sh[POS_W-1:0];
    end
  end

  always_comb begin
    div_req.start    = (state_q == S_PDIV) || (state_q == S_HDIV);
    div_req.dividend = (state_q == S_PDIV) ? (ACC_W'(s_sum) <<< Q_SHIFT) : prod_q;
    div_req.divisor  = (state_q == S_PDIV) ? WEIGHT_SUM : n_eff;
  end

  always_comb begin
    mem_req.re = 1'b0;
    mem_req.we = 1'b0;
    mem_wdata  = row_q;
    if (state_q == S_IDLE) begin
      mem_req.re = s_acc && in_range;
    end else if (state_q == S_READ) begin
      mem_req.we = (op_q == OP_STOP);
      mem_wdata  = '0;
    end else if (state_q == S_OUT) begin
      mem_req.we     = out_free;
      mem_wdata.tick = k_next;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (s_acc && in_range) state_d = S_READ;
      S_READ: begin
        if (op_q == OP_STOP) begin
          state_d = S_IDLE;
        end else if (rd_k == '0) begin
          state_d = S_PDIV;
        end else begin
          state_d = S_MUL;
        end
      end
      S_PDIV:   state_d = S_PWAIT;
      S_PWAIT:  if (div_rsp.done) state_d = pi_q ? S_COEF_D : S_PDIV;
      S_COEF_D: state_d = S_COEF_C;
      S_COEF_C: state_d = S_MUL;
      S_MUL:    state_d = S_HDIV;
      S_HDIV:   state_d = S_HWAIT;
      S_HWAIT:  if (div_rsp.done) state_d = (hs_q == 2'd2) ? S_OUT : S_MUL;
      S_OUT:    if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  assign cfg_we = psel && penable && pwrite && !paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ticks_q   <= TICKS_RESET;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we) begin
        ticks_q <= pwdata[TICK_W-1:0];
      end
      if (state_q == S_OUT && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        op_q   <= s_axis_tuser;
        axis_q <= s_axis_tdata[2:0];
        tgt_q  <= s_axis_tdata[34:3];
        pi_q   <= 1'b0;
        hs_q   <= '0;
      end
      S_READ: begin
        k_q     <= rd_k;
        start_q <= (rd_k == '0);
        row_q   <= rd_row;
        acc_q   <= ACC_W'($signed(mem_rdata.coef[3]));
      end
      S_PWAIT: begin
        if (div_rsp.done) begin
          pi_q <= 1'b1;
          if (pi_q) begin
            acc_q <= div_rsp.quot;
          end else begin
            row_q.coef[0] <= div_rsp.quot[COEF_W-1:0];
          end
        end
      end
      S_COEF_D: begin
        d_q           <= acc_q - ACC_W'(p1);
        row_q.coef[1] <= v1;
      end
      S_COEF_C: begin
        row_q.coef <= {COEF_W'(c3_full), COEF_W'(c2_full), row_q.coef[1], row_q.coef[0]};
        acc_q      <= c3_full;
      end
      S_MUL: begin
        prod_q <= ACC_W'(acc_q * $signed({1'b0, k_q}));
      end
      S_HWAIT: begin
        if (div_rsp.done) begin
          acc_q <= div_rsp.quot + c_add;
          hs_q  <= hs_q + 1'b1;
        end
      end
      S_OUT: begin
        if (out_free) begin
          m_data_q <= {5'b0, pos, axis_q};
          m_user_q <= start_q;
        end
      end
      default: begin
      end
    endcase
  end

  scti_row_mem #(
    .DEPTH (NUM_AXES),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  scti_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;
  assign prdata        = paddr[2] ? 32'h0 : {24'h0, ticks_q};
  assign pready        = 1'b1;

  `SCTI_ASSERT(a_we_state, mem_req.we |-> (state_q == S_READ || state_q == S_OUT), "stray row write")
  `SCTI_ASSERT(a_done_wait, div_rsp.done |-> (state_q == S_PWAIT || state_q == S_HWAIT), "unexpected divide result")
  `SCTI_ASSERT(a_start_idle, div_req.start |-> !div_rsp.busy, "divider restarted while busy")
  `SCTI_ASSERT_NEXT(a_out_load, (state_q == S_OUT) && out_free, m_axis_tvalid && (state_q == S_IDLE), "result not loaded")

endmodule
